// ===== rtl/core/spd_pkg.sv =====
// Shared types and constants for the serial packet deframer.
package spd_pkg;

  localparam logic       REG_SYNC_VALUE = 1'b0;
  localparam logic       REG_MAX_LENGTH = 1'b1;
  localparam logic [7:0] SYNC_RESET     = 8'hAA;
  localparam logic [6:0] MAXLEN_RESET   = 7'd64;
  localparam logic       ST_GOOD        = 1'b0;
  localparam logic       ST_CSUM_ERR    = 1'b1;

  typedef struct packed {
    logic take_id;
    logic take_len;
    logic take_data;
    logic clr_cnt;
    logic inc_cnt;
    logic load_err;
    logic load_zero;
    logic load_pay;
  } spd_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic len_bad;
    logic rx_zero;
    logic len_zero;
    logic data_done;
    logic xor_ok;
    logic burst_last;
    logic out_busy;
  } spd_status_t;

endpackage

// ===== rtl/core/spd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/spd_datapath.sv =====
// Datapath: configuration registers, frame header, checksum, payload store, result register.
module spd_datapath
  import spd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [7:0]  rx_byte,
  input  logic        out_ready,
  input  spd_cmd_t    cmd,
  output spd_status_t status,
  output logic        out_valid,
  output logic [7:0]  frame_id,
  output logic [6:0]  frame_length,
  output logic [7:0]  payload_byte,
  output logic [5:0]  byte_position,
  output logic        frame_status,
  output logic        last
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

  logic [7:0]    sync_value;
  logic [6:0]    max_length;
  logic [7:0]    held_id;
  logic [6:0]    held_length;
  logic [7:0]    running_xor;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_plus;
  logic [8:0]    limit;
  logic [7:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
      max_length <= MAXLEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SYNC_VALUE: sync_value <= cfg_data;
        REG_MAX_LENGTH: max_length <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_id     <= '0;
      held_length <= '0;
      running_xor <= '0;
      cnt         <= '0;
    end else begin
      if (cmd.take_id) begin
        held_id     <= rx_byte;
        running_xor <= rx_byte;
      end
      if (cmd.take_len) begin
        held_length <= rx_byte[6:0];
        running_xor <= running_xor ^ rx_byte;
      end
      if (cmd.take_data) begin
        running_xor <= running_xor ^ rx_byte;
      end
      if (cmd.clr_cnt) begin
        cnt <= '0;
      end else if (cmd.inc_cnt) begin
        cnt <= cnt_plus;
      end
    end
  end

  assign cnt_plus = cnt + CW'(1);

  // The length limit is the smaller of the register and the store depth.
  assign limit = (9'(max_length) > 9'(PAYLOAD_DEPTH)) ? 9'(PAYLOAD_DEPTH) : 9'(max_length);

  assign status.sync_hit   = (rx_byte == sync_value);
  assign status.len_bad    = (9'(rx_byte) > limit);
  assign status.rx_zero    = (rx_byte == 8'd0);
  assign status.len_zero   = (held_length == 7'd0);
  assign status.data_done  = (8'(cnt_plus) >= 8'(held_length));
  assign status.xor_ok     = (rx_byte == running_xor);
  assign status.burst_last = (8'(cnt_plus) == 8'(held_length));
  assign status.out_busy   = out_valid & ~out_ready;

  spd_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.take_data),
    .waddr (cnt[AW-1:0]),
    .wdata (rx_byte),
    .raddr (cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_err || cmd.load_zero || cmd.load_pay) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err || cmd.load_zero) begin
      frame_id      <= held_id;
      frame_length  <= held_length;
      payload_byte  <= '0;
      byte_position <= '0;
      frame_status  <= cmd.load_err ? ST_CSUM_ERR : ST_GOOD;
      last          <= 1'b1;
    end else if (cmd.load_pay) begin
      frame_id      <= held_id;
      frame_length  <= held_length;
      payload_byte  <= ram_rdata;
      byte_position <= 6'(cnt);
      frame_status  <= ST_GOOD;
      last          <= status.burst_last;
    end
  end

endmodule

// ===== rtl/core/spd_ctrl.sv =====
// Controller: frame phase sequencing and payload readout burst.
module spd_ctrl
  import spd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  spd_status_t status,
  output spd_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_HUNT  = 7'b0000001,
    S_ID    = 7'b0000010,
    S_LEN   = 7'b0000100,
    S_DATA  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_RD    = 7'b0100000,
    S_LD    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   fire;

  // The check byte can load the result register, so it waits while that is full and not being taken.
  assign in_ready = (state == S_HUNT) || (state == S_ID) || (state == S_LEN) ||
                    (state == S_DATA) || ((state == S_CHECK) && !status.out_busy);
  assign fire = in_valid & in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_HUNT: begin
        if (fire && status.sync_hit) state_next = S_ID;
      end
      S_ID: begin
        if (fire) begin
          cmd.take_id = 1'b1;
          state_next  = S_LEN;
        end
      end
      S_LEN: begin
        if (fire) begin
          cmd.clr_cnt = 1'b1;
          if (status.len_bad) begin
            state_next = S_HUNT;
          end else begin
            cmd.take_len = 1'b1;
            // A zero length byte skips the payload and goes to the check byte.
            state_next   = status.rx_zero ? S_CHECK : S_DATA;
          end
        end
      end
      S_DATA: begin
        if (fire) begin
          cmd.take_data = 1'b1;
          cmd.inc_cnt   = 1'b1;
          if (status.data_done) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (fire) begin
          if (!status.xor_ok) begin
            cmd.load_err = 1'b1;
            state_next   = S_HUNT;
          end else if (status.len_zero) begin
            cmd.load_zero = 1'b1;
            state_next    = S_HUNT;
          end else begin
            cmd.clr_cnt = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      S_RD: begin
        state_next = S_LD;
      end
      S_LD: begin
        if (!status.out_busy) begin
          cmd.load_pay = 1'b1;
          cmd.inc_cnt  = 1'b1;
          state_next   = status.burst_last ? S_HUNT : S_RD;
        end
      end
      default: state_next = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/serial_packet_deframer.sv =====
// Top level of the serial packet deframer.
//
// Channel   Direction  Handshake             Payload
// in        request    in_valid / in_ready   rx_byte
// out       result     out_valid / out_ready frame_id, frame_length, payload_byte,
//                                            byte_position, status, last
// cfg       write      cfg_write             cfg_index, cfg_data
//
// Each received byte takes one cycle while a frame is being collected.
// A good frame of N > 0 payload bytes gives N results, read from the payload
// store's registered port one by one; input waits during that burst. The check
// byte waits while an earlier result is not taken. Synchronous active-high reset
// restores all but the result data registers and returns to sync hunting.
module serial_packet_deframer
  import spd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_id,
  output logic [6:0] frame_length,
  output logic [7:0] payload_byte,
  output logic [5:0] byte_position,
  output logic       status,
  output logic       last
);

  spd_cmd_t    cmd;
  spd_status_t dp_status;

  spd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (cmd)
  );

  spd_datapath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx_byte),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .status        (dp_status),
    .out_valid     (out_valid),
    .frame_id      (frame_id),
    .frame_length  (frame_length),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .frame_status  (status),
    .last          (last)
  );

endmodule
